/* rtl/srfp_pkg.sv */
// Shared types and constants for the sonar range frame parser.
`default_nettype none
package srfp_pkg;

  localparam int RANGE_W     = 10;
  localparam int RATE_W      = 31;
  localparam int TICK_RATE_W = 20;
  localparam int PROD_W      = RANGE_W + TICK_RATE_W;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 2;

  localparam int MUL_STEPS = RANGE_W;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [7:0]             CR_BYTE          = 8'd13;
  localparam logic [7:0]             DIGIT_LO         = 8'd48;
  localparam logic [7:0]             DIGIT_HI         = 8'd57;
  localparam logic [RANGE_W-1:0]     RANGE_MAX        = 10'd999;
  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET  = 20'd1000000;
  localparam logic [7:0]             START_CHAR_RESET = 8'd82;

  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_RATE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR = 2'd1;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_DIG1 = 3'd1,
    PH_DIG2 = 3'd2,
    PH_DIG3 = 3'd3,
    PH_CR   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_value;
    logic [RANGE_W-1:0] mag;
    logic               neg;
  } frame_t;

endpackage
`default_nettype wire

/* rtl/srfp_parse.sv */
// Frame parser: start character, three digits, carriage return; tick counter.
`default_nettype none
module srfp_parse #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      item_valid,
  input  wire                      kind,
  input  wire  [7:0]               data_byte,
  input  wire  [7:0]               start_char,
  output srfp_pkg::frame_t         frame,
  output logic [ELAPSED_WIDTH-1:0] divisor,
  output logic                     frame_valid
);

  srfp_pkg::phase_t phase, phase_next;
  logic [srfp_pkg::RANGE_W-1:0] digit_accum;
  logic [srfp_pkg::RANGE_W-1:0] previous_range;
  logic [ELAPSED_WIDTH-1:0]     elapsed_ticks;

  logic       byte_item, tick_item, is_dig;
  logic       acc_first, acc_step, frame_fire;
  logic [3:0] digit;
  logic [13:0] mac;

  assign byte_item = item_valid && !kind;
  assign tick_item = item_valid && kind;
  assign is_dig    = (data_byte >= srfp_pkg::DIGIT_LO) && (data_byte <= srfp_pkg::DIGIT_HI);
  assign digit     = data_byte[3:0];
  assign mac       = 14'({digit_accum, 3'b000}) + 14'({digit_accum, 1'b0}) + 14'(digit);

  always_comb begin
    phase_next = phase;
    if (byte_item) begin
      unique case (phase)
        srfp_pkg::PH_DIG1: phase_next = is_dig ? srfp_pkg::PH_DIG2 : srfp_pkg::PH_WAIT;
        srfp_pkg::PH_DIG2: phase_next = is_dig ? srfp_pkg::PH_DIG3 : srfp_pkg::PH_WAIT;
        srfp_pkg::PH_DIG3: phase_next = is_dig ? srfp_pkg::PH_CR : srfp_pkg::PH_WAIT;
        srfp_pkg::PH_CR:   phase_next = srfp_pkg::PH_WAIT;
        default: begin
          phase_next = (data_byte == start_char) ? srfp_pkg::PH_DIG1 : srfp_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_comb begin
    acc_first  = 1'b0;
    acc_step   = 1'b0;
    frame_fire = 1'b0;
    if (byte_item) begin
      unique case (phase) inside
        srfp_pkg::PH_DIG1:                   acc_first  = is_dig;
        srfp_pkg::PH_DIG2, srfp_pkg::PH_DIG3: acc_step   = is_dig;
        srfp_pkg::PH_CR:                     frame_fire = (data_byte == srfp_pkg::CR_BYTE);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= srfp_pkg::PH_WAIT;
      digit_accum    <= '0;
      previous_range <= '0;
      elapsed_ticks  <= '0;
      frame_valid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      frame_valid <= frame_fire;
      if (acc_first) begin
        digit_accum <= srfp_pkg::RANGE_W'(digit);
      end else if (acc_step) begin
        digit_accum <= mac[srfp_pkg::RANGE_W-1:0];
      end
      // saturate at all ones
      if (tick_item && (elapsed_ticks != '1)) begin
        elapsed_ticks <= elapsed_ticks + 1'b1;
      end else if (frame_fire) begin
        elapsed_ticks <= '0;
      end
      if (frame_fire) begin
        previous_range <= digit_accum;
      end
    end
  end

  // snapshot of the finished frame, held until the next one
  always_ff @(posedge clk) begin
    if (frame_fire) begin
      frame.range_value <= digit_accum;
      frame.neg         <= digit_accum < previous_range;
      frame.mag         <= (digit_accum < previous_range) ? previous_range - digit_accum
                                                          : digit_accum - previous_range;
      divisor           <= (elapsed_ticks == '0) ? ELAPSED_WIDTH'(1) : elapsed_ticks;
    end
  end

endmodule
`default_nettype wire

/* rtl/srfp_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module srfp_mul (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire  [srfp_pkg::RANGE_W-1:0]         mplier,
  input  wire  [srfp_pkg::TICK_RATE_W-1:0]     mcand,
  output logic [srfp_pkg::PROD_W-1:0]          product,
  output logic                                 done
);

  localparam int CNT_W = $clog2(srfp_pkg::MUL_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(srfp_pkg::MUL_STEPS - 1);

  logic [srfp_pkg::TICK_RATE_W-1:0] acc;
  logic [srfp_pkg::RANGE_W-1:0]     q;
  logic [srfp_pkg::TICK_RATE_W-1:0] m;
  logic [CNT_W-1:0]                 cnt;
  logic                             busy;
  logic [srfp_pkg::TICK_RATE_W:0]   sum;

  assign sum     = {1'b0, acc} + (q[0] ? {1'b0, m} : '0);
  assign product = {acc, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      q   <= mplier;
      m   <= mcand;
    end else if (busy) begin
      // add then shift the pair right one place
      acc <= sum[srfp_pkg::TICK_RATE_W:1];
      q   <= {sum[0], q[srfp_pkg::RANGE_W-1:1]};
    end
  end

endmodule
`default_nettype wire

/* rtl/srfp_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module srfp_div #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [srfp_pkg::PROD_W-1:0]  dividend,
  input  wire  [ELAPSED_WIDTH-1:0]     divisor,
  output logic [srfp_pkg::PROD_W-1:0]  quotient,
  output logic                         done
);

  localparam int CNT_W = $clog2(srfp_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(srfp_pkg::DIV_STEPS - 1);

  logic [ELAPSED_WIDTH-1:0] rem;
  logic [ELAPSED_WIDTH:0]   trial, diff;
  logic                     fits;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;

  assign trial = {rem, quotient[srfp_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quotient register shifts the dividend out and the result bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[ELAPSED_WIDTH-1:0] : trial[ELAPSED_WIDTH-1:0];
      quotient <= {quotient[srfp_pkg::PROD_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* rtl/sonar_range_frame_parser.sv */
// Throughput: the slave side is held off after each complete frame while the shift-add
//   multiplier (10 steps) and the restoring divider (30 steps) run, and while a result waits
//   for the output register to free; otherwise one transaction per cycle. Once loaded, a result
//   waits in the output register without blocking.
// Reset: synchronous; parser idle, counts and previous range cleared, tick_rate 1000000,
//   start_char 'R'.
`default_nettype none
module sonar_range_frame_parser #(
  parameter int ELAPSED_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [7:0]                          s_axis_tdata,  // data_byte
  input  wire                                 s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [srfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // range_value, range_rate, zero pad
  input  wire                                 cfg_we,
  input  wire  [srfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [srfp_pkg::TICK_RATE_W-1:0]    cfg_data
);

  logic [srfp_pkg::TICK_RATE_W-1:0] tick_rate;
  logic [7:0]                       start_char;

  srfp_pkg::ctl_state_t state, state_next;
  srfp_pkg::frame_t     frame;
  logic [ELAPSED_WIDTH-1:0]      divisor;
  logic                          frame_valid;
  logic                          mul_start, mul_done, div_start, div_done, load, out_free;
  logic [srfp_pkg::PROD_W-1:0]   product, quotient;
  logic [srfp_pkg::RATE_W-1:0]   rate_mag, rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate  <= srfp_pkg::TICK_RATE_RESET;
      start_char <= srfp_pkg::START_CHAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srfp_pkg::CFG_TICK_RATE:  tick_rate  <= cfg_data;
        srfp_pkg::CFG_START_CHAR: start_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  srfp_parse #(.ELAPSED_WIDTH(ELAPSED_WIDTH)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_axis_tvalid && s_axis_tready),
    .kind        (s_axis_tuser),
    .data_byte   (s_axis_tdata),
    .start_char  (start_char),
    .frame       (frame),
    .divisor     (divisor),
    .frame_valid (frame_valid)
  );

  srfp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mplier  (frame.mag),
    .mcand   (tick_rate),
    .product (product),
    .done    (mul_done)
  );

  srfp_div #(.ELAPSED_WIDTH(ELAPSED_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      srfp_pkg::CS_IDLE: if (frame_valid) state_next = srfp_pkg::CS_MUL;
      srfp_pkg::CS_MUL:  if (mul_done)    state_next = srfp_pkg::CS_DIV;
      srfp_pkg::CS_DIV: begin
        if (div_done) state_next = out_free ? srfp_pkg::CS_IDLE : srfp_pkg::CS_HOLD;
      end
      srfp_pkg::CS_HOLD: if (out_free) state_next = srfp_pkg::CS_IDLE;
      default: state_next = srfp_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    load          = 1'b0;
    unique case (state)
      srfp_pkg::CS_IDLE: begin
        s_axis_tready = 1'b1;
        mul_start     = frame_valid;
      end
      srfp_pkg::CS_MUL:  div_start = mul_done;
      srfp_pkg::CS_DIV:  load      = div_done && out_free;
      srfp_pkg::CS_HOLD: load      = out_free;
      default: ;
    endcase
  end

  assign rate_mag = {1'b0, quotient};
  assign rate     = frame.neg ? '0 - rate_mag : rate_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srfp_pkg::CS_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= srfp_pkg::OUT_TDATA_W'({rate, frame.range_value});
    end
  end

endmodule
`default_nettype wire

/* rtl/srfp_check.sv */
// Port-level checker for the sonar range frame parser, bound to the top level.
`default_nettype none
module srfp_check (
  input wire                                clk,
  input wire                                rst,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire [7:0]                          s_axis_tdata,
  input wire                                s_axis_tuser,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [srfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_range_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[srfp_pkg::RANGE_W-1:0] <= srfp_pkg::RANGE_MAX)
    else $error("range above 999");

  // back-pressure starts only after an accepted carriage-return byte
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser, 2)
                             && ($past(s_axis_tdata, 2) == srfp_pkg::CR_BYTE))
    else $error("input stalled without a finished frame");

endmodule

bind sonar_range_frame_parser srfp_check u_srfp_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
